### src/nwt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Number-to-word token package
// Shared widths, token codes and the status type of the token emitter.
// ----------------------------------------------------------------------------
package nwt_pkg;

  localparam int unsigned NumW   = 31;
  localparam int unsigned WordW  = 5;
  localparam int unsigned NumDig = 10;
  localparam int unsigned CntW   = 5;

  // Token codes.
  localparam logic [WordW-1:0] TOK_ZERO     = 5'd0;
  localparam logic [WordW-1:0] TOK_TEN      = 5'd10;
  localparam logic [WordW-1:0] TOK_TENS_OFS = 5'd18;
  localparam logic [WordW-1:0] TOK_HUNDRED  = 5'd28;
  localparam logic [WordW-1:0] TOK_SCALE    = 5'd28;

  typedef logic [NumDig-1:0][3:0] digits_t;

  typedef struct packed {
    logic idle;
    logic done;
  } emit_stat_t;

endpackage

### src/nwt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Number-to-word token channels
// Valid/ready channels for the input number and the output word tokens.
// ----------------------------------------------------------------------------
interface nwt_num_if;
  logic        valid;
  logic        ready;
  logic [30:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

interface nwt_tok_if;
  logic       valid;
  logic       ready;
  logic [4:0] word;
  logic       last_word;

  modport source (output valid, output word, output last_word, input ready);
  modport sink   (input valid, input word, input last_word, output ready);
endinterface

### src/nwt_bcd.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary to BCD converter
// Shift-and-add-3 unit that converts one bit per cycle into ten digits.
// ----------------------------------------------------------------------------
module nwt_bcd (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [30:0]          number_i,
  output logic                 done_o,
  output nwt_pkg::digits_t     digits_o
);
  import nwt_pkg::*;

  localparam logic [CntW-1:0] LastCnt = CntW'(NumW - 1);

  logic [NumW-1:0] bin_q, bin_d;
  digits_t         bcd_q, bcd_d;
  digits_t         adj;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            run_q, run_d;
  logic            done_q, done_d;

  // Digits of five or more get three added before each shift.
  always_comb begin
    for (int i = 0; i < NumDig; i++) begin
      adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
    end
  end

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      bin_d = number_i;
      bcd_d = '0;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      {bcd_d, bin_d} = {adj, bin_q} << 1;
      cnt_d          = cnt_q + 1'b1;
      if (cnt_q == LastCnt) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign done_o   = done_q;
  assign digits_o = bcd_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> cnt_q <= LastCnt)
    else $error("bcd counter past last shift");
  a_done_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !run_q)
    else $error("bcd done while still shifting");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !run_q)
    else $error("bcd restarted while shifting");

endmodule

### src/nwt_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Word token emitter
// Walks the four digit groups and pushes at most one word token per step.
// ----------------------------------------------------------------------------
module nwt_emit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  nwt_pkg::digits_t    digits_i,
  output nwt_pkg::emit_stat_t stat_o,
  nwt_tok_if.source           tok_o
);
  import nwt_pkg::*;

  typedef enum logic [1:0] {E_IDLE, E_RUN, E_DONE} state_e;
  typedef enum logic [2:0] {PH_HD, PH_HW, PH_TN, PH_UN, PH_SC} phase_e;

  state_e           state_q;
  phase_e           phase_q;
  logic [1:0]       grp_q;
  logic             pend_v_q;
  logic [WordW-1:0] pend_q;
  logic             out_v_q;
  logic [WordW-1:0] word_q;
  logic             last_q;
  logic             done_q;

  logic [3:0]       hd, td, ud;
  logic             gnz;
  logic             tok_v;
  logic [WordW-1:0] tok;
  logic             can_push;
  logic             push;

  // Digits of the current group; the billion group has only one digit.
  always_comb begin
    unique case (grp_q)
      2'd3:    begin hd = 4'd0;        td = 4'd0;        ud = digits_i[9]; end
      2'd2:    begin hd = digits_i[8]; td = digits_i[7]; ud = digits_i[6]; end
      2'd1:    begin hd = digits_i[5]; td = digits_i[4]; ud = digits_i[3]; end
      default: begin hd = digits_i[2]; td = digits_i[1]; ud = digits_i[0]; end
    endcase
    gnz = (hd != 4'd0) || (td != 4'd0) || (ud != 4'd0);
  end

  always_comb begin
    tok_v = 1'b0;
    tok   = TOK_ZERO;
    unique case (phase_q)
      PH_HD: begin
        tok_v = (hd != 4'd0);
        tok   = {1'b0, hd};
      end
      PH_HW: begin
        tok_v = (hd != 4'd0);
        tok   = TOK_HUNDRED;
      end
      PH_TN: begin
        if (td == 4'd1) begin
          tok_v = 1'b1;
          tok   = TOK_TEN + {1'b0, ud};
        end else if (td != 4'd0) begin
          tok_v = 1'b1;
          tok   = TOK_TENS_OFS + {1'b0, td};
        end else begin
          tok_v = (ud != 4'd0);
          tok   = {1'b0, ud};
        end
      end
      PH_UN: begin
        tok_v = (td >= 4'd2) && (ud != 4'd0);
        tok   = {1'b0, ud};
      end
      PH_SC: begin
        tok_v = (grp_q != 2'd0) && gnz;
        tok   = TOK_SCALE + {3'b000, grp_q};
      end
      default: begin
        tok_v = 1'b0;
        tok   = TOK_ZERO;
      end
    endcase
  end

  assign can_push = !out_v_q || tok_o.ready;

  // A token moves into the output register when a newer one displaces the
  // held token, or when the walk closes and the held token becomes the last.
  assign push = can_push &&
                (((state_q == E_RUN) && tok_v && pend_v_q) || (state_q == E_DONE));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= E_IDLE;
      phase_q  <= PH_HD;
      grp_q    <= 2'd3;
      pend_v_q <= 1'b0;
      pend_q   <= TOK_ZERO;
      out_v_q  <= 1'b0;
      word_q   <= TOK_ZERO;
      last_q   <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      done_q <= (state_q == E_DONE) && can_push;
      if (push) begin
        out_v_q <= 1'b1;
      end else if (tok_o.ready) begin
        out_v_q <= 1'b0;
      end
      unique case (state_q)
        E_IDLE: begin
          if (start_i) begin
            state_q  <= E_RUN;
            phase_q  <= PH_HD;
            grp_q    <= 2'd3;
            pend_v_q <= 1'b0;
          end
        end
        E_RUN: begin
          if (can_push) begin
            if (tok_v) begin
              if (pend_v_q) begin
                word_q  <= pend_q;
                last_q  <= 1'b0;
              end
              pend_q   <= tok;
              pend_v_q <= 1'b1;
            end
            if (phase_q == PH_SC) begin
              phase_q <= PH_HD;
              grp_q   <= grp_q - 2'd1;
              if (grp_q == 2'd0) begin
                state_q <= E_DONE;
              end
            end else begin
              phase_q <= phase_e'(phase_q + 3'd1);
            end
          end
        end
        E_DONE: begin
          // The held token is the final one; a number with no tokens is zero.
          if (can_push) begin
            word_q   <= pend_v_q ? pend_q : TOK_ZERO;
            last_q   <= 1'b1;
            pend_v_q <= 1'b0;
            state_q  <= E_IDLE;
          end
        end
        default: state_q <= E_IDLE;
      endcase
    end
  end

  assign tok_o.valid     = out_v_q;
  assign tok_o.word      = word_q;
  assign tok_o.last_word = last_q;
  assign stat_o.idle     = (state_q == E_IDLE);
  assign stat_o.done     = done_q;

  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == E_IDLE) |-> !pend_v_q)
    else $error("token held while emitter idle");
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> out_v_q && last_q)
    else $error("finish without a final token");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> (state_q == E_IDLE))
    else $error("emitter started while busy");

endmodule

### src/number_to_word_tokens_top.sv
`timescale 1ns / 1ps
// The accepted number is loaded and converted to BCD at one bit per cycle, then 20 sequencer
// steps walk the four digit groups and one closing step follows; output stalls delay the
// tokens. A new number is accepted only once the emitter has finished the previous one,
// so the BCD unit, the five-step walk of each group and the release of the block set the
// rate; output stalls slow it too. Reset clears all control state at once.
// ----------------------------------------------------------------------------
// Number to word tokens, top level
// Spells a 31-bit number as English number-word tokens, one per transaction.
// ----------------------------------------------------------------------------
module number_to_word_tokens_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  nwt_num_if.sink    number_i,
  nwt_tok_if.source  token_o
);
  import nwt_pkg::*;

  // The block takes one number at a time. It is busy from the accepting
  // transaction until the emitter has placed the final token in its output
  // register; that token may still wait there while the next number enters.
  logic       busy_q;
  logic       accept;
  logic       bcd_done;
  digits_t    digits;
  emit_stat_t emit_stat;

  assign number_i.ready = !busy_q;
  assign accept         = number_i.valid && !busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (accept) begin
      busy_q <= 1'b1;
    end else if (emit_stat.done) begin
      busy_q <= 1'b0;
    end
  end

  // The shift-and-add-3 unit turns the number into ten decimal digits.
  nwt_bcd u_bcd (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept),
    .number_i (number_i.number),
    .done_o   (bcd_done),
    .digits_o (digits)
  );

  // The sequencer walks billion, million, thousand and unit groups in turn.
  // It holds back one token so that the final one can carry last_word.
  nwt_emit u_emit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (bcd_done),
    .digits_i (digits),
    .stat_o   (emit_stat),
    .tok_o    (token_o)
  );

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q)
    else $error("not busy after accepting a number");
  a_free_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> emit_stat.idle)
    else $error("emitter active while block is free");
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bcd_done |-> busy_q)
    else $error("conversion finished with no number accepted");

endmodule
